@@ rtl/utf16be_to_utf8_transcoder_unit_macros.svh @@
// Assertion macros shared by the transcoder RTL files.
`ifndef UTF16BE_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH
`define UTF16BE_TO_UTF8_TRANSCODER_UNIT_MACROS_SVH
`ifndef SYNTH
// Checks a property on every clock edge outside reset.
`define U2U_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Checks that a condition implies a consequence in the same cycle.
`define U2U_IMPLY(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
// Checks that a condition implies a consequence in the next cycle.
`define U2U_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define U2U_ASSERT(lbl, prop, msg)
`define U2U_IMPLY(lbl, cond, cons, msg)
`define U2U_NEXT(lbl, cond, cons, msg)
`endif
`endif

@@ rtl/utf8tc_pkg.sv @@
// Types, constants and encoding functions shared by the transcoder modules.
`default_nettype none
package utf8tc_pkg;

    localparam logic [15:0] SURR_HI_FIRST = 16'hD800;
    localparam logic [15:0] SURR_HI_LAST  = 16'hDBFF;
    localparam logic [15:0] SURR_LO_FIRST = 16'hDC00;
    localparam logic [31:0] PLANE1_BASE   = 32'h0001_0000;
    localparam logic [31:0] LIMIT_1BYTE   = 32'h0000_0080;
    localparam logic [31:0] LIMIT_2BYTE   = 32'h0000_0800;
    localparam logic [31:0] LIMIT_3BYTE   = 32'h0001_0000;
    localparam logic [7:0]  LEAD_2BYTE    = 8'hC0;
    localparam logic [7:0]  LEAD_3BYTE    = 8'hE0;
    localparam logic [7:0]  LEAD_4BYTE    = 8'hF0;
    localparam logic [7:0]  CONT_BYTE     = 8'h80;
    localparam logic [7:0]  QMARK         = 8'h3F;

    // The pair combination folded into one constant, modulo 2^32.
    localparam logic [31:0] SURR_OFFSET = PLANE1_BASE - ({16'h0, SURR_HI_FIRST} << 10)
                                          - {16'h0, SURR_LO_FIRST};

    localparam logic SRC_UTF16 = 1'b0;
    localparam logic SRC_BYTE  = 1'b1;

    typedef enum logic [1:0] {
        ENC_LEN1,
        ENC_LEN2,
        ENC_LEN3,
        ENC_LEN4
    } t_enc_len;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } t_out_item;

    typedef struct packed {
        logic [31:0] code;
        t_enc_len    len;
    } t_q_entry;

    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_wr;

    typedef struct packed {
        logic     valid;
        t_q_entry entry;
    } t_q_rd;

    function automatic t_enc_len enc_len(input logic [31:0] code);
        t_enc_len len;
        if (code < LIMIT_1BYTE) begin
            len = ENC_LEN1;
        end else if (code < LIMIT_2BYTE) begin
            len = ENC_LEN2;
        end else if (code < LIMIT_3BYTE) begin
            len = ENC_LEN3;
        end else begin
            len = ENC_LEN4;
        end
        return len;
    endfunction

    // Byte number idx of the UTF-8 form of code, counted from the lead byte.
    function automatic logic [7:0] enc_byte(input logic [31:0] code, input t_enc_len len,
                                            input logic [1:0] idx);
        logic [7:0] b;
        logic [7:0] cont0;
        logic [7:0] cont1;
        logic [7:0] cont2;
        cont0 = CONT_BYTE | {2'b00, code[5:0]};
        cont1 = CONT_BYTE | {2'b00, code[11:6]};
        cont2 = CONT_BYTE | {2'b00, code[17:12]};
        b = code[7:0];
        case (len)
            ENC_LEN1: begin
                b = code[7:0];
            end
            ENC_LEN2: begin
                b = (idx == 2'd0) ? (LEAD_2BYTE | code[13:6]) : cont0;
            end
            ENC_LEN3: begin
                case (idx)
                    2'd0:    b = LEAD_3BYTE | code[19:12];
                    2'd1:    b = cont1;
                    default: b = cont0;
                endcase
            end
            ENC_LEN4: begin
                case (idx)
                    2'd0:    b = LEAD_4BYTE | code[25:18];
                    2'd1:    b = cont2;
                    2'd2:    b = cont1;
                    default: b = cont0;
                endcase
            end
            default: begin
                b = code[7:0];
            end
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/utf16be_to_utf8_transcoder_unit.sv @@
// Top level of the UTF-16 big-endian to UTF-8 transcoder.
//
// Input channel: one raw string byte per item with a mark on the final byte,
// taken when i_in_valid is high and o_in_stall is low. Output channel: one
// UTF-8 byte per item; run_last marks the last byte caused by one input item.
// The one-bit configuration register selects UTF-16 big-endian (0) or
// single-byte text (1) and is written whenever i_cfg_wr_en is high.
// The front end pairs bytes and forms code points; a queue of QUEUE_DEPTH
// code points decouples it from the back end, which emits one byte a cycle
// while the receiver does not stall. A code point is queued at the edge
// that takes the input item completing it; the back end then registers its
// bytes into the output item. The input side takes one item a cycle while
// the queue has room; the output side gives one byte a cycle unless stalled
// and so sets the pace: a three-byte unit comes from two input bytes.
// Reset clears the mode to UTF-16, drops any half-paired unit and empties
// the queue. When the receiver stalls the output item holds, the queue fills
// and o_in_stall rises once it is full.
`default_nettype none
module utf16be_to_utf8_transcoder_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire utf8tc_pkg::t_in_item  i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output utf8tc_pkg::t_out_item      o_out_item,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic                  i_cfg_wr_data
);
    import utf8tc_pkg::*;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    utf8tc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_wr          (q_wr)
    );

    utf8tc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    utf8tc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd        (q_rd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

@@ rtl/utf8tc_front.sv @@
// Front end: takes input items, pairs bytes into units and forms code points.
`default_nettype none
`include "utf16be_to_utf8_transcoder_unit_macros.svh"
module utf8tc_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire utf8tc_pkg::t_in_item i_in_item,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic                 i_cfg_wr_data,
    input  wire logic                 i_q_full,
    output utf8tc_pkg::t_q_wr         o_wr
);
    import utf8tc_pkg::*;

    logic        r_mode;
    logic        r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_high_unit, n_high_unit;
    logic        r_have_high, n_have_high;

    logic        accept;
    logic [15:0] unit;
    logic [31:0] code;
    logic        push;

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign unit       = {r_held, i_in_item.in_byte};

    always_comb begin
        n_phase     = r_phase;
        n_held      = r_held;
        n_high_unit = r_high_unit;
        n_have_high = r_have_high;
        push        = 1'b0;
        code        = {24'h0, i_in_item.in_byte};
        if (accept) begin
            if (r_mode == SRC_BYTE) begin
                push = 1'b1;
                code = i_in_item.in_byte[7] ? {24'h0, QMARK} : {24'h0, i_in_item.in_byte};
            end else if (!r_phase) begin
                n_held  = i_in_item.in_byte;
                n_phase = 1'b1;
                if (i_in_item.last_byte && r_have_high) begin
                    push = 1'b1;
                    code = {16'h0, r_high_unit};
                end
            end else begin
                n_phase = 1'b0;
                if (r_have_high) begin
                    // Any following unit completes the pair, in range or not.
                    push        = 1'b1;
                    code        = ({16'h0, r_high_unit} << 10) + {16'h0, unit} + SURR_OFFSET;
                    n_have_high = 1'b0;
                end else if (unit >= SURR_HI_FIRST && unit <= SURR_HI_LAST
                             && !i_in_item.last_byte) begin
                    n_high_unit = unit;
                    n_have_high = 1'b1;
                end else begin
                    push = 1'b1;
                    code = {16'h0, unit};
                end
            end
            if (i_in_item.last_byte) begin
                n_phase     = 1'b0;
                n_held      = '0;
                n_high_unit = '0;
                n_have_high = 1'b0;
            end
        end
    end

    always_comb begin
        o_wr.push      = push;
        o_wr.entry.code = code;
        o_wr.entry.len  = enc_len(code);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= SRC_UTF16;
            r_phase     <= 1'b0;
            r_held      <= '0;
            r_high_unit <= '0;
            r_have_high <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            r_phase     <= n_phase;
            r_held      <= n_held;
            r_high_unit <= n_high_unit;
            r_have_high <= n_have_high;
        end
    end

    `U2U_IMPLY(a_high_is_surrogate, r_have_high, r_high_unit[15:10] == 6'b110110, "pending unit is not a high surrogate")
    `U2U_NEXT(a_end_clears, accept && i_in_item.last_byte, !r_phase && !r_have_high, "string state survives the last item")

endmodule
`default_nettype wire

@@ rtl/utf8tc_queue.sv @@
// Short queue of code points between the front and back ends.
`default_nettype none
`include "utf16be_to_utf8_transcoder_unit_macros.svh"
module utf8tc_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire utf8tc_pkg::t_q_wr i_wr,
    output logic                   o_full,
    output utf8tc_pkg::t_q_rd      o_rd,
    input  wire logic              i_pop
);
    import utf8tc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full         = (r_count == CNT_W'(DEPTH));
    assign o_rd.valid     = (r_count != '0);
    assign o_rd.entry     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_mem[r_wr_ptr] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr.push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_wr.push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_wr.push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `U2U_IMPLY(a_no_push_full, i_wr.push, !o_full, "push into a full queue")
    `U2U_IMPLY(a_no_pop_empty, i_pop, o_rd.valid, "pop from an empty queue")

endmodule
`default_nettype wire

@@ rtl/utf8tc_back.sv @@
// Back end: spells queued code points as UTF-8 bytes, one per cycle unless stalled.
`default_nettype none
`include "utf16be_to_utf8_transcoder_unit_macros.svh"
module utf8tc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire utf8tc_pkg::t_q_rd i_rd,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output utf8tc_pkg::t_out_item  o_out_item
);
    import utf8tc_pkg::*;

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out_item;
    logic       load;
    logic       final_byte;

    assign load        = i_rd.valid && (!r_out_valid || !i_out_stall);
    assign final_byte  = (r_idx == 2'(i_rd.entry.len));
    assign o_pop       = load && final_byte;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_item.out_byte <= enc_byte(i_rd.entry.code, i_rd.entry.len, r_idx);
            r_out_item.run_last <= final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= final_byte ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `U2U_IMPLY(a_idx_in_range, i_rd.valid, r_idx <= 2'(i_rd.entry.len), "byte index past the code point length")

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the UTF-16 big-endian to UTF-8 transcoder.
module testbench;
    import utf8tc_pkg::*;

    localparam int STUCK_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 200;

    // One row of the directed table. Where typed is set, the expected bytes are
    // given in typed_bytes, first byte in the top eight bits.
    typedef struct packed {
        logic        mode;
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [2:0]  n_typed;
        logic [31:0] typed_bytes;
    } t_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_stall = 1'b0;
    logic      out_hold = 1'b0;
    logic      cfg_wr_en = 1'b0;
    logic      cfg_wr_data = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int send_idle = 0;
    int recv_stall = 0;
    int bytes_taken = 0;
    int mismatches = 0;

    // Predicted state of the transcoder.
    logic        src_mode = SRC_UTF16;
    logic        low_due = 1'b0;
    logic [7:0]  high_byte = '0;
    logic [15:0] surr_unit = '0;
    logic        surr_held = 1'b0;
    t_out_item   step_out [4];
    t_out_item   utf8_due [$];
    t_row        dir_rows [$];

    utf16be_to_utf8_transcoder_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_item    (in_item),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (out_stall),
        .o_out_item   (o_out_item),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_error(input string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic encode_code(input logic [31:0] code, output int n);
        if (code < LIMIT_1BYTE) begin
            step_out[0].out_byte = code[7:0];
            n = 1;
        end else if (code < LIMIT_2BYTE) begin
            step_out[0].out_byte = LEAD_2BYTE | code[13:6];
            step_out[1].out_byte = CONT_BYTE | {2'b00, code[5:0]};
            n = 2;
        end else if (code < LIMIT_3BYTE) begin
            step_out[0].out_byte = LEAD_3BYTE | code[19:12];
            step_out[1].out_byte = CONT_BYTE | {2'b00, code[11:6]};
            step_out[2].out_byte = CONT_BYTE | {2'b00, code[5:0]};
            n = 3;
        end else begin
            step_out[0].out_byte = LEAD_4BYTE | code[25:18];
            step_out[1].out_byte = CONT_BYTE | {2'b00, code[17:12]};
            step_out[2].out_byte = CONT_BYTE | {2'b00, code[11:6]};
            step_out[3].out_byte = CONT_BYTE | {2'b00, code[5:0]};
            n = 4;
        end
    endtask

    // Works out the UTF-8 bytes that one accepted input byte causes.
    task automatic predict_step(input logic [7:0] b, input logic last, output int n);
        logic [15:0] unit;
        logic [31:0] code;
        int i;
        n = 0;
        if (src_mode == SRC_BYTE) begin
            step_out[0].out_byte = (b < 8'h80) ? b : QMARK;
            n = 1;
        end else if (!low_due) begin
            high_byte = b;
            low_due = 1'b1;
            if (last && surr_held) begin
                encode_code({16'h0, surr_unit}, n);
            end
        end else begin
            unit = {high_byte, b};
            low_due = 1'b0;
            if (surr_held) begin
                // The second unit is taken as it is, so the sum may wrap.
                code = PLANE1_BASE + (({16'h0, surr_unit} - {16'h0, SURR_HI_FIRST}) << 10)
                       + ({16'h0, unit} - {16'h0, SURR_LO_FIRST});
                surr_held = 1'b0;
                encode_code(code, n);
            end else if (unit >= SURR_HI_FIRST && unit <= SURR_HI_LAST && !last) begin
                surr_unit = unit;
                surr_held = 1'b1;
            end else begin
                encode_code({16'h0, unit}, n);
            end
        end
        if (last) begin
            low_due = 1'b0;
            high_byte = '0;
            surr_unit = '0;
            surr_held = 1'b0;
        end
        for (i = 0; i < 4; i++) begin
            step_out[i].run_last = (i == n - 1);
        end
    endtask

    // Offers one item, waits for it to be taken and queues what it should cause.
    // The valid is left high so that a following item can go out back to back.
    task automatic send_byte(input logic [7:0] data, input logic last, input logic typed,
                             input int n_typed, input logic [31:0] typed_bytes);
        int n;
        int i;
        t_out_item fixed;
        while ($urandom_range(0, 99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= {data, last};
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
        bytes_taken++;
        predict_step(data, last, n);
        if (typed) begin
            for (i = 0; i < n_typed; i++) begin
                fixed.out_byte = typed_bytes[31 - 8 * i -: 8];
                fixed.run_last = (i == n_typed - 1);
                utf8_due = {utf8_due, fixed};
            end
        end else begin
            for (i = 0; i < n; i++) begin
                fixed = step_out[i];
                utf8_due = {utf8_due, fixed};
            end
        end
    endtask

    // Drops valid and waits until every predicted byte has come out and the
    // block has had time to finish a unit that causes no output.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (utf8_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic mode);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        src_mode = mode;
    endtask

    task automatic add_row(input logic mode, input logic [7:0] data, input logic last,
                           input logic typed, input int n, input logic [31:0] bytes);
        t_row row;
        row = {mode, data, last, typed, n[2:0], bytes};
        dir_rows = {dir_rows, row};
    endtask

    // Mostly well-formed text with random content, some lone surrogates,
    // arbitrary units and trailing odd bytes mixed in.
    task automatic send_utf16_string();
        logic [7:0]  seq [$];
        logic [15:0] unit;
        logic [7:0]  odd_byte;
        int n_units;
        int i;
        n_units = $urandom_range(1, 5);
        for (i = 0; i < n_units; i++) begin
            case ($urandom_range(0, 9))
                0, 1: unit = 16'($urandom_range(0, 16'h7F));
                2, 3: unit = 16'($urandom_range(16'h80, 16'h7FF));
                4, 5: unit = 16'($urandom_range(16'h800, 16'hFFFF));
                6, 7: begin
                    unit = 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST));
                    seq = {seq, unit[15:8], unit[7:0]};
                    unit = 16'($urandom_range(SURR_LO_FIRST, 16'hDFFF));
                end
                8: unit = 16'($urandom_range(SURR_HI_FIRST, SURR_HI_LAST));
                default: unit = 16'($urandom);
            endcase
            seq = {seq, unit[15:8], unit[7:0]};
        end
        if ($urandom_range(0, 5) == 0) begin
            odd_byte = 8'($urandom_range(0, 255));
            seq = {seq, odd_byte};
        end
        for (i = 0; i < seq.size(); i++) begin
            send_byte(seq[i], i == seq.size() - 1, 1'b0, 0, '0);
        end
    endtask

    task automatic send_byte_string();
        int len;
        int i;
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1, 1'b0, 0, '0);
        end
    endtask

    task automatic run_phase(input int n_items);
        int stop_at;
        stop_at = bytes_taken + n_items;
        while (bytes_taken < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                set_mode(src_mode == SRC_UTF16 ? SRC_BYTE : SRC_UTF16);
            end
            if (src_mode == SRC_BYTE) begin
                send_byte_string();
            end else begin
                send_utf16_string();
            end
        end
        wait_idle();
    endtask

    always @(posedge i_clk) begin : out_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !out_stall) begin
            if (utf8_due.size() == 0) begin
                note_error($sformatf("byte %h with none expected", o_out_item.out_byte));
            end else begin
                want = utf8_due.pop_front();
                if (o_out_item.out_byte !== want.out_byte) begin
                    note_error($sformatf("out_byte %h, expected %h",
                                         o_out_item.out_byte, want.out_byte));
                end
                if (o_out_item.run_last !== want.run_last) begin
                    note_error($sformatf("run_last %b, expected %b on byte %h",
                                         o_out_item.run_last, want.run_last, want.out_byte));
                end
            end
        end
        out_stall <= out_hold || ($urandom_range(0, 99) < recv_stall);
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if ((in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !out_stall)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int i;
        int hold_stop;
        t_row r;
        // "A" then U+FFFF, the top of the basic plane.
        add_row(SRC_UTF16, 8'h00, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'h41, 1'b0, 1'b1, 1, 32'h4100_0000);
        add_row(SRC_UTF16, 8'hFF, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'hFF, 1'b1, 1'b1, 3, 32'hEFBF_BF00);
        // The first supplementary code point from a proper pair.
        add_row(SRC_UTF16, 8'hD8, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'hDC, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b1, 1'b1, 4, 32'hF090_8080);
        // Top high surrogate joined to a unit outside the low range.
        add_row(SRC_UTF16, 8'hDB, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'hFF, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'hFF, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'hFF, 1'b1, 1'b0, 0, 32'h0);
        // The string ends on an odd byte while a high surrogate waits.
        add_row(SRC_UTF16, 8'hD8, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b0, 1'b1, 0, 32'h0);
        add_row(SRC_UTF16, 8'h41, 1'b1, 1'b1, 3, 32'hEDA0_8000);
        // A low surrogate with nothing before it.
        add_row(SRC_UTF16, 8'hDC, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b0, 1'b0, 0, 32'h0);
        // A pending surrogate must survive single-byte items in between.
        add_row(SRC_UTF16, 8'hD8, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_BYTE,  8'h7F, 1'b0, 1'b1, 1, 32'h7F00_0000);
        add_row(SRC_BYTE,  8'h80, 1'b0, 1'b1, 1, 32'h3F00_0000);
        add_row(SRC_UTF16, 8'hDC, 1'b0, 1'b0, 0, 32'h0);
        add_row(SRC_UTF16, 8'h00, 1'b1, 1'b0, 0, 32'h0);
        add_row(SRC_BYTE,  8'hFF, 1'b1, 1'b1, 1, 32'h3F00_0000);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < dir_rows.size(); i++) begin
            r = dir_rows[i];
            if (r.mode != src_mode) begin
                set_mode(r.mode);
            end
            send_byte(r.data, r.last, r.typed, r.n_typed, r.typed_bytes);
        end

        // The output is held off long enough for the block to fill and stall its input.
        set_mode(SRC_UTF16);
        hold_stop = bytes_taken + 24;
        fork
            begin
                out_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_hold <= 1'b0;
            end
            while (bytes_taken < hold_stop) begin
                send_utf16_string();
            end
        join
        run_phase(12);

        send_idle = 45;
        recv_stall = 0;
        run_phase(26);
        send_idle = 0;
        recv_stall = 45;
        run_phase(26);
        send_idle = 22;
        recv_stall = 22;
        run_phase(26);

        repeat (20) @(posedge i_clk);
        if (utf8_due.size() != 0) begin
            note_error($sformatf("%0d bytes never came out", utf8_due.size()));
        end
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/utf8tc_pkg.sv
rtl/utf8tc_front.sv
rtl/utf8tc_queue.sv
rtl/utf8tc_back.sv
rtl/utf16be_to_utf8_transcoder_unit.sv
test/testbench.sv
